// File: hw/rtl/lmd_pkg.sv
`timescale 1ns / 1ps
package lmd_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QUEUE_AW + 1;

	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] count;
	} lmd_qstat_t;

endpackage

// File: hw/rtl/lmd_front.sv
`timescale 1ns / 1ps
module lmd_front import lmd_pkg::*; #(
	parameter int MAX_SIDE    = 1024,
	parameter int SAMPLE_BITS = 16,
	parameter int IDX_W       = $clog2(MAX_SIDE),
	parameter int SIDE_W      = IDX_W + 1,
	parameter int Q_W         = 3 * SAMPLE_BITS + 2 * IDX_W + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [SIDE_W-1:0]      cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  lmd_qstat_t             qstat,
	output logic                   push,
	output logic [Q_W-1:0]         push_data
);

	logic [SIDE_W-1:0]        side_q;
	logic [SIDE_W-1:0]        side_eff;
	logic [IDX_W-1:0]         row_q;
	logic [IDX_W-1:0]         col_q;
	logic [SIDE_W-1:0]        col_inc;
	logic [SIDE_W-1:0]        row_inc;
	logic                     accept;

	logic                     valid_s1;
	logic [SAMPLE_BITS-1:0]   sample_s1;
	logic [IDX_W-1:0]         slot_s1;
	logic [IDX_W-1:0]         row_s1;
	logic [IDX_W-1:0]         col_s1;
	logic                     interior_s1;
	logic [2*SAMPLE_BITS-1:0] word_s1;

	logic [2*SAMPLE_BITS-1:0] line_mem [MAX_SIDE];

	assign in_ready = (qstat.count + QCNT_W'(valid_s1)) < QCNT_W'(QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;

	always_comb begin
		priority if (side_q == '0) begin
			side_eff = SIDE_W'(1);
		end else if (side_q > SIDE_W'(MAX_SIDE)) begin
			side_eff = SIDE_W'(MAX_SIDE);
		end else begin
			side_eff = side_q;
		end
	end

	assign col_inc = SIDE_W'(col_q) + SIDE_W'(1);
	assign row_inc = SIDE_W'(row_q) + SIDE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_W'(3);
			row_q  <= '0;
			col_q  <= '0;
		end else begin
			priority if (cfg_we) begin
				side_q <= cfg_data;
				row_q  <= '0;
				col_q  <= '0;
			end else if (accept) begin
				if (col_inc >= side_eff) begin
					col_q <= '0;
					if (row_inc >= side_eff) begin
						row_q <= '0;
					end else begin
						row_q <= row_inc[IDX_W-1:0];
					end
				end else begin
					col_q <= col_inc[IDX_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1   <= in_sample;
			slot_s1     <= col_q;
			row_s1      <= row_q - IDX_W'(1);
			col_s1      <= col_q - IDX_W'(1);
			interior_s1 <= (row_q >= IDX_W'(2)) && (col_q >= IDX_W'(2));
		end
	end

	// shift the column down: old middle becomes upper, new sample becomes middle
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= line_mem[col_q];
		end
		if (valid_s1) begin
			line_mem[slot_s1] <= {word_s1[SAMPLE_BITS-1:0], sample_s1};
		end
	end

	assign push      = valid_s1;
	assign push_data = {interior_s1, row_s1, col_s1, word_s1, sample_s1};

endmodule

// File: hw/rtl/lmd_queue.sv
`timescale 1ns / 1ps
module lmd_queue import lmd_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output lmd_qstat_t       qstat
);

	logic [WIDTH-1:0]    entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data    = entry_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.count = count_q;

endmodule

// File: hw/rtl/lmd_back.sv
`timescale 1ns / 1ps
module lmd_back import lmd_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int IDX_W       = 10,
	parameter int Q_W         = 3 * SAMPLE_BITS + 2 * IDX_W + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lmd_qstat_t             qstat,
	input  logic [Q_W-1:0]         pop_data,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [IDX_W-1:0]       out_row,
	output logic [IDX_W-1:0]       out_col,
	output logic [SAMPLE_BITS-1:0] out_value
);

	logic signed [SAMPLE_BITS-1:0] win_q   [9];
	logic signed [SAMPLE_BITS-1:0] win_nxt [9];
	logic signed [SAMPLE_BITS-1:0] e_sample;
	logic signed [SAMPLE_BITS-1:0] e_mid;
	logic signed [SAMPLE_BITS-1:0] e_top;
	logic [IDX_W-1:0]              e_col;
	logic [IDX_W-1:0]              e_row;
	logic                          e_interior;
	logic                          hit;

	logic                          valid_q;
	logic [IDX_W-1:0]              row_q;
	logic [IDX_W-1:0]              col_q;
	logic [SAMPLE_BITS-1:0]        value_q;

	assign {e_interior, e_row, e_col, e_top, e_mid, e_sample} = pop_data;

	assign pop = !qstat.empty && (!valid_q || out_ready);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_nxt[k*3+0] = win_q[k*3+1];
			win_nxt[k*3+1] = win_q[k*3+2];
		end
		win_nxt[2] = e_top;
		win_nxt[5] = e_mid;
		win_nxt[8] = e_sample;
	end

	always_comb begin
		hit = e_interior;
		for (int k = 0; k < 9; k++) begin
			if (k != 4 && !(win_nxt[k] < win_nxt[4])) begin
				hit = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (pop) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= win_nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= hit;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && hit) begin
			row_q   <= e_row;
			col_q   <= e_col;
			value_q <= win_nxt[4];
		end
	end

	assign out_valid = valid_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign out_value = value_q;

endmodule

// File: hw/rtl/local_max_3x3_detector_top.sv
`timescale 1ns / 1ps
// channel   | direction | handshake                    | payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: sample_value
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: max_row, max_col, max_value
// cfg       | in        | cfg_we                       | cfg_data: matrix_side
// One sample is taken per cycle while s_axis_tready is high; the read stage reads the line
// store and writes the queue, and the compare registers its result as it pops the queue.
// Reset clears counters, queue and window; the line store holds garbage until written.
// A stall on m_axis backs up into a four-entry queue; s_axis_tready drops once the
// queue and the read stage hold four requests.
module local_max_3x3_detector_top import lmd_pkg::*; #(
	parameter int MAX_SIDE    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [$clog2(MAX_SIDE):0]   cfg_data,       // matrix_side
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // sample_value
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// max_row, max_col, max_value
	output logic [((2*$clog2(MAX_SIDE)+SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

	localparam int IDX_W  = $clog2(MAX_SIDE);
	localparam int SIDE_W = IDX_W + 1;
	localparam int OUT_W  = ((2 * IDX_W + SAMPLE_BITS + 7) / 8) * 8;
	localparam int Q_W    = 3 * SAMPLE_BITS + 2 * IDX_W + 1;

	lmd_qstat_t             qstat;
	logic                   push;
	logic [Q_W-1:0]         push_data;
	logic                   pop;
	logic [Q_W-1:0]         pop_data;
	logic [IDX_W-1:0]       out_row;
	logic [IDX_W-1:0]       out_col;
	logic [SAMPLE_BITS-1:0] out_value;

	lmd_front #(
		.MAX_SIDE    (MAX_SIDE),
		.SAMPLE_BITS (SAMPLE_BITS),
		.IDX_W       (IDX_W),
		.SIDE_W      (SIDE_W),
		.Q_W         (Q_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	lmd_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	lmd_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.IDX_W       (IDX_W),
		.Q_W         (Q_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value)
	);

	assign m_axis_tdata = OUT_W'({out_value, out_col, out_row});

endmodule

// File: hw/rtl/lmd_checker.sv
`timescale 1ns / 1ps
module lmd_checker #(
	parameter int MAX_SIDE    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_we,
	input logic [$clog2(MAX_SIDE):0]   cfg_data,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [((2*$clog2(MAX_SIDE)+SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

	localparam int IDX_W = $clog2(MAX_SIDE);

	logic [IDX_W-1:0] row;
	logic [IDX_W-1:0] col;

	assign row = m_axis_tdata[IDX_W-1:0];
	assign col = m_axis_tdata[2*IDX_W-1:IDX_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> row != '0 && col != '0)
		else $error("border position reported at row or column zero");

	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> row != {IDX_W{1'b1}} && col != {IDX_W{1'b1}})
		else $error("reported position beyond interior");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output stall");

endmodule

bind local_max_3x3_detector_top lmd_checker #(
	.MAX_SIDE    (MAX_SIDE),
	.SAMPLE_BITS (SAMPLE_BITS)
) u_lmd_checker (.*);

// File: bench/local_max_3x3_detector_checker.sv
`timescale 1ns / 1ps
module local_max_3x3_detector_checker #(
	parameter int MAX_SIDE    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  cfg_we,
	input  logic [$clog2(MAX_SIDE):0]                             cfg_data,
	input  logic                                                  s_axis_tvalid,
	input  logic                                                  s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]                      s_axis_tdata,
	input  logic                                                  m_axis_tvalid,
	input  logic                                                  m_axis_tready,
	input  logic [((2*$clog2(MAX_SIDE)+SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata,
	output int                                                    errors,
	output int                                                    pending
);

	localparam int RB = $clog2(MAX_SIDE);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic [RB-1:0] row;
		logic [RB-1:0] col;
		sample_t       value;
	} peak_t;

	sample_t     upper_line [MAX_SIDE];
	sample_t     middle_line [MAX_SIDE];
	sample_t     win [9];
	int unsigned row_n;
	int unsigned col_n;
	int unsigned side_used;
	peak_t       peaks_due [$];

	initial errors = 0;
	initial pending = 0;

	always @(posedge clk or negedge arst_n) begin : track
		sample_t     x;
		sample_t     top;
		sample_t     mid;
		bit          strict;
		int unsigned slot;
		peak_t       want;
		peak_t       got;

		if (!arst_n) begin
			for (int i = 0; i < MAX_SIDE; i++) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			for (int k = 0; k < 9; k++)
				win[k] = '0;
			row_n     = 0;
			col_n     = 0;
			side_used = 3;
			peaks_due.delete();
			pending <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				x    = s_axis_tdata[SAMPLE_BITS-1:0];
				slot = col_n % MAX_SIDE;
				top  = upper_line[slot];
				mid  = middle_line[slot];
				upper_line[slot]  = mid;
				middle_line[slot] = x;
				for (int k = 0; k < 3; k++) begin
					win[k*3]   = win[k*3+1];
					win[k*3+1] = win[k*3+2];
				end
				win[2] = top;
				win[5] = mid;
				win[8] = x;
				if (row_n >= 2 && col_n >= 2) begin
					strict = 1'b1;
					for (int k = 0; k < 9; k++)
						if (k != 4 && !(win[k] < win[4]))
							strict = 1'b0;
					if (strict) begin
						want.row   = RB'(row_n - 1);
						want.col   = RB'(col_n - 1);
						want.value = win[4];
						peaks_due.push_back(want);
					end
				end
				col_n++;
				if (col_n >= side_used) begin
					col_n = 0;
					row_n++;
					if (row_n >= side_used)
						row_n = 0;
				end
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got.row   = m_axis_tdata[RB-1:0];
				got.col   = m_axis_tdata[2*RB-1:RB];
				got.value = m_axis_tdata[2*RB+SAMPLE_BITS-1:2*RB];
				if (peaks_due.size() == 0) begin
					$display("%0t: expected none, got row %0d col %0d value %0d",
						$time, got.row, got.col, got.value);
					errors++;
				end else begin
					want = peaks_due.pop_front();
					if (got != want) begin
						$write("%0t: expected row %0d col %0d value %0d, ",
							$time, want.row, want.col, want.value);
						$display("got row %0d col %0d value %0d",
							got.row, got.col, got.value);
						errors++;
					end
				end
			end

			if (cfg_we) begin
				if (cfg_data == 0)
					side_used = 1;
				else if (cfg_data > MAX_SIDE)
					side_used = MAX_SIDE;
				else
					side_used = cfg_data;
				row_n = 0;
				col_n = 0;
			end

			pending <= peaks_due.size();
		end
	end

endmodule

// File: bench/local_max_3x3_detector_top_tb.sv
`timescale 1ns / 1ps
module local_max_3x3_detector_top_tb;

	localparam int MAX_SIDE    = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int CW          = $clog2(MAX_SIDE) + 1;
	localparam int SW          = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int MW          = ((2 * $clog2(MAX_SIDE) + SAMPLE_BITS + 7) / 8) * 8;
	localparam int LIMIT       = 500000;
	localparam int RANDOM_ITEMS = 1830;

	typedef enum int {FILL_WIDE, FILL_NARROW, FILL_EXTREME, FILL_PEAKS} fill_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [CW-1:0] cfg_data = '0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [SW-1:0] s_axis_tdata = '0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [MW-1:0] m_axis_tdata;

	int errors;
	int pending;
	int cycles = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	local_max_3x3_detector_top #(
		.MAX_SIDE    (MAX_SIDE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	local_max_3x3_detector_checker #(
		.MAX_SIDE    (MAX_SIDE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) peak_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (errors),
		.pending       (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("local_max_3x3_detector_top_tb failed");
			$finish;
		end
	end

	function automatic int draw_wait(bit calm);
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(fill_t mode);
		case (mode)
			FILL_NARROW: begin
				return SAMPLE_BITS'($urandom_range(0, 4) - 2);
			end
			FILL_EXTREME: begin
				if ($urandom_range(0, 1))
					return SAMPLE_BITS'(16'sh7FFF - $urandom_range(0, 1));
				return SAMPLE_BITS'(16'sh8000 + $urandom_range(0, 1));
			end
			FILL_PEAKS: begin
				if ($urandom_range(0, 4) == 0)
					return SAMPLE_BITS'($urandom_range(1000, 32767));
				return SAMPLE_BITS'($urandom_range(0, 200) - 100);
			end
			default: begin
				return SAMPLE_BITS'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v);
		int gap;

		if ($urandom_range(0, 99) == 0)
			send_calm = !send_calm;
		gap = draw_wait(send_calm);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= SW'(v);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_side(input logic [CW-1:0] v);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_grid(input logic signed [SAMPLE_BITS-1:0] centre,
			input logic signed [SAMPLE_BITS-1:0] rim);
		for (int i = 0; i < 9; i++)
			send_sample(i == 4 ? centre : rim);
	endtask

	task automatic send_run(input int count, input fill_t mode);
		for (int i = 0; i < count; i++)
			send_sample(pick_sample(mode));
	endtask

	initial begin : receiver
		int stall;

		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 99) == 0)
				recv_calm = !recv_calm;
			stall = draw_wait(recv_calm);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int    sent;
		int    side;
		int    pick;
		int    reps;
		int    count;
		fill_t mode;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// side of three out of reset: one interior cell per matrix
		send_grid(16'sh7FFF, 16'sh8000);
		send_grid(16'sh8001, 16'sh8000);
		send_grid(16'sh0000, 16'sh0000);

		write_side(CW'(0));
		send_run(4, FILL_WIDE);
		write_side(CW'(1));
		send_run(3, FILL_WIDE);
		write_side(CW'(2));
		send_run(9, FILL_WIDE);
		write_side(CW'(2047));
		send_run(30, FILL_WIDE);
		write_side(CW'(1024));
		send_run(30, FILL_WIDE);
		write_side(CW'(3));
		send_run(18, FILL_PEAKS);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				side = $urandom_range(13, 24);
			else if (pick == 1)
				side = $urandom_range(1, 2);
			else
				side = $urandom_range(3, 12);
			write_side(CW'(side));
			reps = $urandom_range(1, 3);
			for (int m = 0; m < reps; m++) begin
				mode  = fill_t'($urandom_range(0, 3));
				count = side * side;
				if (count > 1 && $urandom_range(0, 5) == 0)
					count = $urandom_range(1, side * side - 1);
				send_run(count, mode);
				sent += count;
				if (count < side * side || sent >= RANDOM_ITEMS)
					break;
				if ($urandom_range(0, 7) == 0)
					settle();
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("local_max_3x3_detector_top_tb passed");
		else
			$display("local_max_3x3_detector_top_tb failed");
		$finish;
	end

endmodule
